>>> rtl/stepper_trapezoid_ramp_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef STEPPER_TRAPEZOID_RAMP_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_MACROS_SVH

// Same-cycle implication.
`define STP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("stepper ramp check failed");

// Next-cycle implication.
`define STP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("stepper ramp check failed");

`endif

>>> rtl/stp_ramp_pkg.sv
package stp_ramp_pkg;

  localparam int unsigned ALPHA_FRAC = 29;
  localparam logic [31:0] ALPHA_TWO_PI = 32'd3373259426;
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;
  localparam logic [1:0] REG_STEPS = 2'd2;

  typedef enum logic [1:0] {
    DIV_ALPHA,
    DIV_RAMP,
    DIV_DV,
    DIV_DLY
  } div_op_e;

  typedef enum logic [1:0] {
    MUL_AA,
    MUL_VSQ,
    MUL_DLY
  } mul_op_e;

  typedef struct packed {
    logic    capture;
    logic    exec;
    logic    div_start;
    div_op_e div_op;
    logic    mul_en;
    mul_op_e mul_op;
    logic    sel_now;
    logic    sqrt_start;
    logic    ld_alpha;
    logic    ld_ext;
    logic    ld_plan;
    logic    ld_dv;
    logic    ld_v0;
    logic    ld_dly;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_cmd;
    logic steps_zero;
    logic extend;
    logic tick_more;
    logic div_done;
    logic div_busy;
    logic sqrt_done;
  } dp_sts_t;

endpackage

>>> rtl/stp_ramp_div.sv
module stp_ramp_div #(
  parameter int NUM_W = 76,
  parameter int DEN_W = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] nq_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, nq_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nq_q  <= {nq_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

>>> rtl/stp_ramp_sqrt.sv
module stp_ramp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;
  logic [33:0] rem_sh, trial, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[31:0], x_q[63:62]};
    trial  = {root_q, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? diff[32:0] : rem_sh[32:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/stp_ramp_dp.sv
module stp_ramp_dp #(
  parameter int STEP_BITS       = 24,
  parameter int SPEED_FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stp_ramp_pkg::ctrl_cmd_t cmd_i,
  output stp_ramp_pkg::dp_sts_t   sts_o,
  input  logic                   in_cmd_i,
  input  logic                   in_dir_i,
  input  logic [23:0]            in_steps_i,
  input  logic [31:0]            in_speed_i,
  input  logic [31:0]            accel_limit_i,
  input  logic [31:0]            speed_limit_i,
  input  logic [15:0]            steps_per_turn_i,
  output logic [3:0]             result_o
);
  import stp_ramp_pkg::*;

  localparam int RAMP_SH = 28 - SPEED_FRAC_BITS;
  localparam int DEN_SH  = ALPHA_FRAC - SPEED_FRAC_BITS;
  localparam int NUM_W   = 64 + RAMP_SH;
  localparam int DEN_W   = 64;
  localparam logic [31:0] ONE_Q   = 32'(64'd1 << SPEED_FRAC_BITS);
  localparam logic [31:0] TENTH_Q = 32'(((64'd1 << SPEED_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

  logic                 in_cmd_q, in_dir_q;
  logic [23:0]          in_steps_q;
  logic [31:0]          in_speed_q;

  logic                 moving_q, dir_q, pulse_q;
  logic [STEP_BITS-1:0] total_q, idx_q, accel_q, decel_q;
  logic [31:0]          inc_q, now_q, goal_q, delay_q, elapsed_q;
  logic [31:0]          alpha_q;
  logic [63:0]          aa_q, prod_q;

  logic [31:0]          steps_w, target, a_eff, mul_a, mul_b, d_half, v_dly;
  logic [15:0]          n_eff;
  logic [STEP_BITS-1:0] steps_c, half, accel_new, tot_new, decel_ext, idx1;
  logic [STEP_BITS:0]   tot_sum;
  logic [63:0]          product;
  logic [NUM_W-1:0]     div_num, quot;
  logic [DEN_W-1:0]     div_den;
  logic [31:0]          quot_sat, root, v0, el1, up_v, down_v;
  logic [32:0]          up_sum;
  logic                 div_start, div_busy, div_done, sqrt_done, hit, fin;

  always_comb begin
    steps_w  = 32'(in_steps_q);
    steps_c  = STEP_BITS'((steps_w > 32'(STEP_MAX)) ? 32'(STEP_MAX) : steps_w);
    half     = steps_c >> 1;
    target   = (in_speed_q != '0) ? in_speed_q : speed_limit_i;
    a_eff    = (accel_limit_i != '0) ? accel_limit_i : 32'd1;
    n_eff    = (steps_per_turn_i != '0) ? steps_per_turn_i : 16'd1;
    d_half   = ((goal_q >> 1) < ONE_Q) ? ONE_Q : (goal_q >> 1);
    v_dly    = (now_q < TENTH_Q) ? TENTH_Q : now_q;

    case (cmd_i.mul_op)
      MUL_AA:  begin mul_a = a_eff; mul_b = alpha_q; end
      MUL_VSQ: begin
        mul_a = cmd_i.sel_now ? now_q : target;
        mul_b = mul_a;
      end
      MUL_DLY: begin mul_a = alpha_q; mul_b = USEC_PER_SEC; end
      default: begin mul_a = alpha_q; mul_b = USEC_PER_SEC; end
    endcase
    product = 64'(mul_a) * 64'(mul_b);

    case (cmd_i.div_op)
      DIV_ALPHA: begin div_num = NUM_W'(ALPHA_TWO_PI); div_den = DEN_W'(n_eff); end
      DIV_RAMP:  begin div_num = NUM_W'(prod_q) << RAMP_SH; div_den = aa_q; end
      DIV_DV:    begin div_num = NUM_W'(aa_q); div_den = DEN_W'(d_half) << DEN_SH; end
      DIV_DLY:   begin div_num = NUM_W'(prod_q); div_den = DEN_W'(v_dly) << DEN_SH; end
      default:   begin div_num = NUM_W'(prod_q); div_den = DEN_W'(v_dly) << DEN_SH; end
    endcase

    quot_sat  = (|quot[NUM_W-1:32]) ? '1 : quot[31:0];
    accel_new = (quot > NUM_W'(half)) ? half : quot[STEP_BITS-1:0];
    tot_sum   = {1'b0, total_q} + {1'b0, steps_c};
    tot_new   = tot_sum[STEP_BITS] ? STEP_MAX : tot_sum[STEP_BITS-1:0];
    decel_ext = (quot >= NUM_W'(tot_new)) ? '0 : tot_new - quot[STEP_BITS-1:0];
    v0        = (root < ONE_Q) ? ONE_Q : root;

    el1    = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
    hit    = moving_q && (el1 >= delay_q);
    idx1   = (&idx_q) ? idx_q : idx_q + 1'b1;
    fin    = idx1 >= total_q;
    up_sum = {1'b0, now_q} + {1'b0, inc_q};
    up_v   = (up_sum > {1'b0, goal_q}) ? goal_q : up_sum[31:0];
    down_v = (inc_q >= now_q) ? ONE_Q : now_q - inc_q;
    if (down_v < ONE_Q) down_v = ONE_Q;
  end

  assign div_start = cmd_i.div_start;

  stp_ramp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (quot)
  );

  stp_ramp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .rad_i  (aa_q >> RAMP_SH),
    .done_o (sqrt_done),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_cmd_q   <= in_cmd_i;
      in_dir_q   <= in_dir_i;
      in_steps_q <= in_steps_i;
      in_speed_q <= in_speed_i;
    end
    if (cmd_i.ld_alpha) alpha_q <= quot[31:0];
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_op == MUL_AA) aa_q <= product;
      else prod_q <= product;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q  <= 1'b0;
      dir_q     <= 1'b0;
      pulse_q   <= 1'b0;
      total_q   <= '0;
      idx_q     <= '0;
      accel_q   <= '0;
      decel_q   <= '0;
      inc_q     <= '0;
      now_q     <= '0;
      goal_q    <= '0;
      delay_q   <= '0;
      elapsed_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        pulse_q <= !in_cmd_q && hit;
        if (!in_cmd_q && moving_q) begin
          if (!hit) begin
            elapsed_q <= el1;
          end else begin
            elapsed_q <= el1 - delay_q;
            idx_q     <= idx1;
            if (fin) begin
              moving_q <= 1'b0;
            end else if (idx1 < accel_q) begin
              now_q <= up_v;
            end else if (idx1 > decel_q) begin
              now_q <= down_v;
            end
          end
        end
      end
      if (cmd_i.ld_ext) begin
        total_q <= tot_new;
        decel_q <= decel_ext;
      end
      if (cmd_i.ld_plan) begin
        accel_q   <= accel_new;
        decel_q   <= steps_c - accel_new;
        total_q   <= steps_c;
        idx_q     <= '0;
        goal_q    <= target;
        dir_q     <= in_dir_q;
        elapsed_q <= '0;
        moving_q  <= 1'b1;
      end
      if (cmd_i.ld_dv)  inc_q   <= quot_sat;
      if (cmd_i.ld_v0)  now_q   <= v0;
      if (cmd_i.ld_dly) delay_q <= quot_sat;
    end
  end

  always_comb begin
    sts_o.is_cmd     = in_cmd_q;
    sts_o.steps_zero = (in_steps_q == '0);
    sts_o.extend     = moving_q && (in_dir_q == dir_q);
    sts_o.tick_more  = hit && !fin;
    sts_o.div_done   = div_done;
    sts_o.div_busy   = div_busy;
    sts_o.sqrt_done  = sqrt_done;
  end

  assign result_o = {moving_q, !moving_q, dir_q, pulse_q};

endmodule

>>> rtl/stp_ramp_ctrl.sv
module stp_ramp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    out_free_i,
  input  stp_ramp_pkg::dp_sts_t   sts_i,
  output logic                    in_ready_o,
  output stp_ramp_pkg::ctrl_cmd_t cmd_o
);
  import stp_ramp_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE       = 16'h0001,
    ST_EXEC       = 16'h0002,
    ST_ALPHA_GO   = 16'h0004,
    ST_ALPHA_WAIT = 16'h0008,
    ST_MUL_AA     = 16'h0010,
    ST_MUL_VV     = 16'h0020,
    ST_RAMP_GO    = 16'h0040,
    ST_RAMP_WAIT  = 16'h0080,
    ST_DV_GO      = 16'h0100,
    ST_DV_WAIT    = 16'h0200,
    ST_SQRT_GO    = 16'h0400,
    ST_SQRT_WAIT  = 16'h0800,
    ST_MUL_DLY    = 16'h1000,
    ST_DLY_GO     = 16'h2000,
    ST_DLY_WAIT   = 16'h4000,
    ST_RESP       = 16'h8000
  } state_e;

  typedef enum logic [1:0] {
    MODE_DLY,
    MODE_EXT,
    MODE_PLAN
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_cmd) begin
          if (sts_i.steps_zero) begin
            state_d = ST_RESP;
          end else begin
            mode_d  = sts_i.extend ? MODE_EXT : MODE_PLAN;
            state_d = ST_ALPHA_GO;
          end
        end else if (sts_i.tick_more) begin
          mode_d  = MODE_DLY;
          state_d = ST_ALPHA_GO;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_ALPHA_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_ALPHA;
        state_d         = ST_ALPHA_WAIT;
      end
      ST_ALPHA_WAIT: begin
        cmd_o.div_op = DIV_ALPHA;
        if (sts_i.div_done) begin
          cmd_o.ld_alpha = 1'b1;
          state_d = (mode_q == MODE_DLY) ? ST_MUL_DLY : ST_MUL_AA;
        end
      end
      ST_MUL_AA: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_AA;
        state_d      = ST_MUL_VV;
      end
      ST_MUL_VV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = MUL_VSQ;
        cmd_o.sel_now = (mode_q == MODE_EXT);
        state_d       = ST_RAMP_GO;
      end
      ST_RAMP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RAMP;
        state_d         = ST_RAMP_WAIT;
      end
      ST_RAMP_WAIT: begin
        cmd_o.div_op = DIV_RAMP;
        if (sts_i.div_done) begin
          if (mode_q == MODE_EXT) begin
            cmd_o.ld_ext = 1'b1;
            state_d      = ST_RESP;
          end else begin
            cmd_o.ld_plan = 1'b1;
            state_d       = ST_DV_GO;
          end
        end
      end
      ST_DV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_DV;
        state_d         = ST_DV_WAIT;
      end
      ST_DV_WAIT: begin
        cmd_o.div_op = DIV_DV;
        if (sts_i.div_done) begin
          cmd_o.ld_dv = 1'b1;
          state_d     = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.ld_v0 = 1'b1;
          state_d     = ST_MUL_DLY;
        end
      end
      ST_MUL_DLY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_DLY;
        state_d      = ST_DLY_GO;
      end
      ST_DLY_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_DLY;
        state_d         = ST_DLY_WAIT;
      end
      ST_DLY_WAIT: begin
        cmd_o.div_op = DIV_DLY;
        if (sts_i.div_done) begin
          cmd_o.ld_dly = 1'b1;
          state_d      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_DLY;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

>>> rtl/stepper_trapezoid_ramp.sv
// Trapezoidal step generator. Each request on the input stream is either a
// one-microsecond tick (tuser low) or a start/extend-move command (tuser
// high); every request yields exactly one result carrying the step pulse,
// direction level, active-low enable and busy flag. Requests are handled one
// at a time, and a new one is taken while the previous result still waits
// on the output. Each divide in a request runs on the shared bit-serial divider,
// one quotient bit per clock over 92 - SPEED_FRAC_BITS bits (76 by default):
// a tick that issues no step or the last step, or a zero-length command,
// needs no divide; a tick that issues any other step recomputes the step
// delay with two divides; an extend takes two divides; a new move plan
// takes four divides plus a square root.
// Registers at byte addresses 0, 4 and 8: accel_limit, speed_limit,
// steps_per_turn; write them only while no request is in flight.
module stepper_trapezoid_ramp #(
  parameter int STEP_BITS       = 24,
  parameter int SPEED_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] move_dir, [24:1] move_steps, [56:25] move_speed, [63:57] zero
  input  logic [63:0] s_tdata,
  // [0] cmd
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] step_pulse, [1] dir_level, [2] enable_n, [3] busy_res, [7:4] zero
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stp_ramp_pkg::*;

`include "stepper_trapezoid_ramp_macros.svh"

  logic [31:0] accel_q, speed_lim_q;
  logic [15:0] spt_q;
  logic        m_valid_q;
  logic [3:0]  m_data_q;
  logic [3:0]  result;
  logic        cfg_wr;
  ctrl_cmd_t   cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q     <= 32'd655360;
      speed_lim_q <= 32'd411775;
      spt_q       <= 16'd200;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ACCEL: accel_q     <= pwdata;
        REG_SPEED: speed_lim_q <= pwdata;
        REG_STEPS: spt_q       <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACCEL: prdata = accel_q;
      REG_SPEED: prdata = speed_lim_q;
      REG_STEPS: prdata = {16'd0, spt_q};
      default:   prdata = '0;
    endcase
  end

  stp_ramp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_tvalid),
    .out_free_i(!m_valid_q || m_tready),
    .sts_i     (sts),
    .in_ready_o(s_tready),
    .cmd_o     (cmd)
  );

  stp_ramp_dp #(
    .STEP_BITS      (STEP_BITS),
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_cmd_i        (s_tuser),
    .in_dir_i        (s_tdata[0]),
    .in_steps_i      (s_tdata[24:1]),
    .in_speed_i      (s_tdata[56:25]),
    .accel_limit_i   (accel_q),
    .speed_limit_i   (speed_lim_q),
    .steps_per_turn_i(spt_q),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) m_data_q <= result;
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {4'd0, m_data_q};

  `STP_ASSERT_NOW(a_busy_vs_enable, clk_i, rst_ni, m_tvalid, m_tdata[3] != m_tdata[2])
  `STP_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_tvalid && s_tready, !s_tready)
  `STP_ASSERT_NOW(a_div_no_restart, clk_i, rst_ni, cmd.div_start, !sts.div_busy)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import stp_ramp_pkg::*;

  localparam longint unsigned STEP_CAP = 64'hFF_FFFF;
  localparam longint unsigned ONE_Q = 64'd65536;
  localparam longint unsigned TENTH_Q = (ONE_Q + 64'd5) / 64'd10;
  localparam longint unsigned U32_CAP = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    bit cmd;
    bit dir;
    bit [23:0] steps;
    bit [31:0] speed;
  } move_req_t;

  typedef struct packed {
    bit busy;
    bit en_n;
    bit dir;
    bit pulse;
  } ramp_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stepper_trapezoid_ramp DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // motion model state
  longint unsigned accel_reg, speed_reg, turn_reg;
  bit moving, direction;
  longint unsigned total_steps, step_index, accel_steps, decel_start;
  longint unsigned speed_inc, speed_now, speed_goal, step_delay, elapsed_us;

  ramp_out_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int requests = 0;
  int results = 0;
  int step_count = 0;
  int hold_cycles = 0;
  bit no_idle = 0;

  function automatic longint unsigned alpha_q();
    longint unsigned n;
    n = (turn_reg == 0) ? 64'd1 : turn_reg;
    return 64'd3373259426 / n;
  endfunction

  function automatic longint unsigned accel_alpha();
    longint unsigned a;
    a = (accel_reg == 0) ? 64'd1 : accel_reg;
    return a * alpha_q();
  endfunction

  function automatic longint unsigned brake_len(longint unsigned v);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, v * v} << 12;
    q = num / {64'd0, accel_alpha()};
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void update_delay();
    longint unsigned v, q;
    v = (speed_now < TENTH_Q) ? TENTH_Q : speed_now;
    q = (alpha_q() * 64'd1000000) / (v << 13);
    step_delay = (q > U32_CAP) ? U32_CAP : q;
  endfunction

  function automatic void plan_move(bit dir, longint unsigned steps, longint unsigned vreq);
    longint unsigned target, n, half, aa, d, dv, v0, brake_dist;
    if (steps == 0) return;
    if (moving && dir == direction) begin
      total_steps = total_steps + steps;
      if (total_steps > STEP_CAP) total_steps = STEP_CAP;
      brake_dist = brake_len(speed_now);
      decel_start = (brake_dist >= total_steps) ? 0 : total_steps - brake_dist;
      return;
    end
    direction = dir;
    target = (vreq != 0) ? vreq : speed_reg;
    n = brake_len(target);
    half = steps / 2;
    accel_steps = (n > half) ? half : n;
    decel_start = steps - accel_steps;
    aa = accel_alpha();
    d = target >> 1;
    if (d < ONE_Q) d = ONE_Q;
    dv = aa / (d << 13);
    speed_inc = (dv > U32_CAP) ? U32_CAP : dv;
    v0 = int_sqrt(aa >> 12);
    if (v0 < ONE_Q) v0 = ONE_Q;
    if (v0 > U32_CAP) v0 = U32_CAP;
    speed_now = v0;
    total_steps = steps;
    step_index = 0;
    speed_goal = target;
    update_delay();
    elapsed_us = 0;
    moving = 1;
  endfunction

  function automatic bit advance_tick();
    longint unsigned v;
    if (!moving) return 0;
    if (elapsed_us < U32_CAP) elapsed_us++;
    if (elapsed_us < step_delay) return 0;
    elapsed_us = elapsed_us - step_delay;
    if (step_index < STEP_CAP) step_index++;
    if (step_index >= total_steps) begin
      moving = 0;
      return 1;
    end
    if (step_index < accel_steps) begin
      v = speed_now + speed_inc;
      speed_now = (v > speed_goal) ? speed_goal : v;
    end else if (step_index > decel_start) begin
      speed_now = (speed_inc >= speed_now) ? ONE_Q : speed_now - speed_inc;
      if (speed_now < ONE_Q) speed_now = ONE_Q;
    end
    update_delay();
    return 1;
  endfunction

  function automatic ramp_out_t predict_motion(move_req_t r);
    ramp_out_t o;
    o.pulse = 0;
    if (r.cmd) plan_move(r.dir, r.steps, r.speed);
    else o.pulse = advance_tick();
    o.dir = direction;
    o.en_n = !moving;
    o.busy = moving;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    ramp_out_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = pending_q.pop_front();
        if (m_tdata[0] !== want.pulse) report_mismatch("step_pulse", m_tdata[0], want.pulse);
        if (m_tdata[1] !== want.dir) report_mismatch("dir_level", m_tdata[1], want.dir);
        if (m_tdata[2] !== want.en_n) report_mismatch("enable_n", m_tdata[2], want.en_n);
        if (m_tdata[3] !== want.busy) report_mismatch("busy_res", m_tdata[3], want.busy);
        if (m_tdata[0] === 1'b1) step_count++;
      end
      results++;
    end
  end

  // receiver with random stalls and commanded long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic send_request(move_req_t r);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 11);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.cmd;
    s_tdata <= {7'd0, r.speed, r.steps, r.dir};
    do @(posedge clk_i); while (!s_tready);
    pending_q.push_back(predict_motion(r));
    requests++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ACCEL: accel_reg = val;
      REG_SPEED: speed_reg = val;
      REG_STEPS: turn_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] accel, logic [31:0] speed, logic [15:0] turn);
    drain();
    write_reg(REG_ACCEL, accel);
    write_reg(REG_SPEED, speed);
    write_reg(REG_STEPS, {16'd0, turn});
  endtask

  function automatic move_req_t tick_req();
    move_req_t r;
    r = '0;
    r.dir = 1'($urandom_range(0, 1));
    r.steps = 24'($urandom);
    r.speed = $urandom;
    return r;
  endfunction

  function automatic move_req_t start_req(bit dir, bit [23:0] steps, bit [31:0] speed);
    move_req_t r;
    r.cmd = 1;
    r.dir = dir;
    r.steps = steps;
    r.speed = speed;
    return r;
  endfunction

  function automatic bit [31:0] pick_speed();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return $urandom_range(1, 32'h0004_0000);
      2: return $urandom_range(32'h0010_0000, 32'h0100_0000);
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_request(tick_req());
    send_request(start_req(1, 24'd0, 32'hFFFF_FFFF));
    send_request(tick_req());
    send_request(start_req(1, 24'd1, 32'd0));
    repeat (3) send_request(tick_req());
    send_request(start_req(1, 24'hFF_FFFF, 32'd0));
    send_request(start_req(1, 24'hFF_FFFF, 32'd1));
    send_request(start_req(0, 24'd9, 32'hFFFF_FFFF));
    send_request(start_req(0, 24'd0, 32'd0));
    repeat (3) send_request(tick_req());
  endtask

  task automatic test_fast_ramps(int budget);
    move_req_t r;
    int used, guard;
    used = 0;
    while (used < budget) begin
      if ($urandom_range(0, 6) == 0) begin
        r = tick_req();
        r.cmd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) r.steps = 24'($urandom_range(0, 3));
        send_request(r);
        used++;
      end else begin
        send_request(start_req(1'($urandom_range(0, 1)), 24'($urandom_range(1, 12)),
                               pick_speed()));
        used++;
        guard = 0;
        while (moving && guard < 120 && used < budget) begin
          if ($urandom_range(0, 30) == 0)
            send_request(start_req(1'($urandom_range(0, 1)), 24'($urandom_range(1, 5)),
                                   pick_speed()));
          else
            send_request(tick_req());
          used++;
          guard++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    no_idle = 1;
    send_request(start_req(0, 24'd6, 32'hFFFF_FFFF));
    hold_cycles = 400;
    repeat (24) send_request(tick_req());
    no_idle = 0;
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) send_request(tick_req());
  endtask

  initial begin
    accel_reg = 655360;
    speed_reg = 411775;
    turn_reg = 200;
    moving = 0;
    direction = 0;
    total_steps = 0; step_index = 0; accel_steps = 0; decel_start = 0;
    speed_inc = 0; speed_now = 0; speed_goal = 0; step_delay = 0; elapsed_us = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    configure(32'hFFFF_FFFF, 32'd411775, 16'd65535);
    test_fast_ramps(220);
    test_backpressure();
    configure(32'h0800_0000, 32'h0200_0000, 16'd4000);
    test_fast_ramps(180);
    configure(32'd1, 32'd1, 16'd1);
    send_request(start_req(1, 24'd3, 32'd0));
    repeat (4) send_request(tick_req());
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd65535);
    test_fast_ramps(120);
    drain();

    $display("covered %0d requests, %0d results, %0d step pulses", requests, results,
             step_count);
    $display("config sweeps: reset values, fastest ramp, mid range, slowest extreme");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
